// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is high.
`define ASSERT_CLK(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("assertion failed");

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) (prop)) \
    else $error("assertion failed");

`endif

// ===== src/tucv_pkg.sv =====
package tucv_pkg;

  localparam int COUNTER_WIDTH    = 32;
  localparam int ETH_HEADER_BYTES = 14;
  localparam int POS_W            = 17;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam int IP_IHL_OFFSET    = 0;
  localparam int IP_LEN_HI_OFFSET = 2;
  localparam int IP_LEN_LO_OFFSET = 3;
  localparam int IP_PROTO_OFFSET  = 9;
  localparam int IP_SRC_OFFSET    = 12;
  localparam int IP_MIN_HEADER    = 20;

  localparam int TCP_CSUM_OFFSET = 16;
  localparam int UDP_CSUM_OFFSET = 6;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

endpackage

// ===== src/tcp_udp_checksum_verifier.sv =====
// Checks the TCP or UDP checksum of Ethernet frames carrying IPv4. Frame bytes enter one per
// cycle while frame_stall is low, from the destination MAC on, with last_byte on the final byte;
// the pseudo-header addresses and the segment are folded into the running one's complement sum
// as they arrive, and the next frame may follow at once unless frame_stall holds it. A finished
// frame is registered in the folding stage for the final carry folding and compare, and the
// outcome is then captured in the result register. frame_stall rises only when a finished frame
// waits in the folding stage while the result register is still held by result_stall. Options
// are handled, an odd segment is padded with a zero byte, bytes past the IP total length are
// ignored, and a frame shorter than its IP total length or a 20-byte header is flagged truncated.
module tcp_udp_checksum_verifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 frame_valid,
  output logic                                 frame_stall,
  input  logic [7:0]                           frame_byte,
  input  logic                                 last_byte,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 is_ipv4,
  output logic [1:0]                           transport_kind,
  output logic [15:0]                          computed_checksum,
  output logic [15:0]                          received_checksum,
  output logic                                 checksum_mismatch,
  output logic                                 frame_truncated,
  output logic [tucv_pkg::COUNTER_WIDTH-1:0]   frames_seen,
  output logic [tucv_pkg::COUNTER_WIDTH-1:0]   ipv4_frames_seen,
  output logic [tucv_pkg::COUNTER_WIDTH-1:0]   mismatches_seen
);

  localparam int PW = tucv_pkg::POS_W;
  localparam int CW = tucv_pkg::COUNTER_WIDTH;
  localparam logic [PW-1:0] ETH_POS = PW'(tucv_pkg::ETH_HEADER_BYTES);
  localparam logic [PW-1:0] MIN_HDR = PW'(tucv_pkg::IP_MIN_HEADER);

  logic [PW-1:0] byte_position, byte_position_next;
  logic [15:0]   ethertype_word, ethertype_next;
  logic [5:0]    ip_header_bytes, header_next;
  logic [15:0]   ip_total_length, total_next;
  logic [7:0]    protocol_code, protocol_next;
  logic [31:0]   running_sum, running_sum_next;
  logic [7:0]    pending_high_byte, pending_next;
  logic [15:0]   stored_checksum, stored_next;

  logic          fin_valid;
  logic          fin_ipv4;
  logic          fin_trunc;
  logic          fin_check;
  logic          fin_tcp;
  logic [31:0]   fin_sum;
  logic [17:0]   fin_extra;
  logic [15:0]   fin_stored;

  logic          accept;
  logic          fin_take;
  logic          pos_live;
  logic          ip_live;
  logic          is_tcp;
  logic          tcpudp;
  logic [PW-1:0] offset;
  logic [PW-1:0] seg_off;
  logic [PW-1:0] csum_off;
  logic          in_pseudo;
  logic          in_seg;
  logic [7:0]    word_byte;
  logic [PW-1:0] ip_bytes;
  logic          done_ipv4;
  logic          long_enough;
  logic          short_len;
  logic          done_trunc;
  logic          done_check;
  logic [PW-1:0] seen;
  logic          pad;
  logic [17:0]   extra;

  logic [31:0]   fold0;
  logic [16:0]   fold1;
  logic [16:0]   fold2;
  logic [15:0]   cs;

  assign fin_take    = fin_valid && (!result_valid || !result_stall);
  assign frame_stall = fin_valid && !fin_take;
  assign accept      = frame_valid && !frame_stall;

  assign is_tcp = protocol_code == tucv_pkg::PROTO_TCP;
  assign tcpudp = is_tcp || protocol_code == tucv_pkg::PROTO_UDP;

  always_comb begin
    byte_position_next = byte_position;
    ethertype_next     = ethertype_word;
    header_next        = ip_header_bytes;
    total_next         = ip_total_length;
    protocol_next      = protocol_code;
    running_sum_next   = running_sum;
    pending_next       = pending_high_byte;
    stored_next        = stored_checksum;
    word_byte          = frame_byte;

    pos_live  = byte_position != tucv_pkg::POS_MAX;
    offset    = byte_position - ETH_POS;
    ip_live   = pos_live && byte_position >= ETH_POS &&
                ethertype_word == tucv_pkg::ETHERTYPE_IPV4;
    seg_off   = offset - PW'(ip_header_bytes);
    csum_off  = is_tcp ? PW'(tucv_pkg::TCP_CSUM_OFFSET) : PW'(tucv_pkg::UDP_CSUM_OFFSET);
    in_pseudo = offset >= PW'(tucv_pkg::IP_SRC_OFFSET) && offset < MIN_HDR;
    in_seg    = PW'(ip_header_bytes) >= MIN_HDR && offset >= PW'(ip_header_bytes) &&
                offset < PW'(ip_total_length) && tcpudp;

    if (pos_live) begin
      byte_position_next = byte_position + PW'(1);
      if (byte_position >= ETH_POS - PW'(2) && byte_position < ETH_POS) begin
        ethertype_next = {ethertype_word[7:0], frame_byte};
      end
    end

    if (ip_live) begin
      if (offset == PW'(tucv_pkg::IP_IHL_OFFSET)) begin
        header_next = {frame_byte[3:0], 2'b00};
      end else if (offset == PW'(tucv_pkg::IP_LEN_HI_OFFSET)) begin
        total_next[15:8] = frame_byte;
      end else if (offset == PW'(tucv_pkg::IP_LEN_LO_OFFSET)) begin
        total_next[7:0] = frame_byte;
      end else if (offset == PW'(tucv_pkg::IP_PROTO_OFFSET)) begin
        protocol_next = frame_byte;
      end

      if (!in_pseudo && in_seg) begin
        if (seg_off == csum_off) begin
          stored_next[15:8] = frame_byte;
          word_byte         = 8'd0;
        end else if (seg_off == csum_off + PW'(1)) begin
          stored_next[7:0] = frame_byte;
          word_byte        = 8'd0;
        end
      end

      if (in_pseudo || in_seg) begin
        if (!offset[0]) begin
          pending_next = word_byte;
        end else begin
          running_sum_next = running_sum + {16'd0, pending_high_byte, word_byte};
        end
      end
    end

    ip_bytes    = byte_position_next - ETH_POS;
    done_ipv4   = byte_position_next >= ETH_POS &&
                  ethertype_next == tucv_pkg::ETHERTYPE_IPV4;
    long_enough = ip_bytes >= MIN_HDR;
    short_len   = ip_bytes < PW'(ip_total_length);
    done_trunc  = done_ipv4 && (!long_enough || short_len);
    done_check  = done_ipv4 && long_enough && tcpudp &&
                  PW'(ip_header_bytes) >= MIN_HDR &&
                  ip_total_length >= 16'(ip_header_bytes);
    seen        = short_len ? ip_bytes : PW'(ip_total_length);
    pad         = seen > PW'(ip_header_bytes) && seen[0];
    extra       = (pad ? {2'b00, pending_next, 8'd0} : 18'd0) + 18'(protocol_code) +
                  18'(ip_total_length - 16'(ip_header_bytes));
  end

  assign fold0 = fin_sum + 32'(fin_extra);
  assign fold1 = 17'(fold0[31:16]) + 17'(fold0[15:0]);
  assign fold2 = 17'(fold1[16]) + fold1;
  assign cs    = ~fold2[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      ethertype_word    <= '0;
      ip_header_bytes   <= '0;
      ip_total_length   <= '0;
      protocol_code     <= '0;
      running_sum       <= '0;
      pending_high_byte <= '0;
      stored_checksum   <= '0;
      fin_valid         <= 1'b0;
      result_valid      <= 1'b0;
      frames_seen       <= '0;
      ipv4_frames_seen  <= '0;
      mismatches_seen   <= '0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          byte_position     <= '0;
          ethertype_word    <= '0;
          ip_header_bytes   <= '0;
          ip_total_length   <= '0;
          protocol_code     <= '0;
          running_sum       <= '0;
          pending_high_byte <= '0;
          stored_checksum   <= '0;
        end else begin
          byte_position     <= byte_position_next;
          ethertype_word    <= ethertype_next;
          ip_header_bytes   <= header_next;
          ip_total_length   <= total_next;
          protocol_code     <= protocol_next;
          running_sum       <= running_sum_next;
          pending_high_byte <= pending_next;
          stored_checksum   <= stored_next;
        end
      end

      if (accept && last_byte) begin
        fin_valid <= 1'b1;
      end else if (fin_take) begin
        fin_valid <= 1'b0;
      end

      if (fin_take) begin
        result_valid <= 1'b1;
        frames_seen  <= frames_seen + CW'(1);
        if (fin_ipv4) begin
          ipv4_frames_seen <= ipv4_frames_seen + CW'(1);
        end
        if (fin_check && cs != fin_stored) begin
          mismatches_seen <= mismatches_seen + CW'(1);
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      fin_ipv4   <= done_ipv4;
      fin_trunc  <= done_trunc;
      fin_check  <= done_check;
      fin_tcp    <= is_tcp;
      fin_sum    <= running_sum_next;
      fin_extra  <= extra;
      fin_stored <= stored_next;
    end
    if (fin_take) begin
      is_ipv4           <= fin_ipv4;
      frame_truncated   <= fin_trunc;
      transport_kind    <= !fin_check ? tucv_pkg::KIND_NONE :
                           fin_tcp    ? tucv_pkg::KIND_TCP  : tucv_pkg::KIND_UDP;
      computed_checksum <= fin_check ? cs : 16'd0;
      received_checksum <= fin_check ? fin_stored : 16'd0;
      checksum_mismatch <= fin_check && cs != fin_stored;
    end
  end

endmodule

// ===== src/tucv_checker.sv =====
`include "assert_macros.svh"

module tucv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic [1:0]                         transport_kind,
  input logic [15:0]                        computed_checksum,
  input logic [15:0]                        received_checksum,
  input logic                               checksum_mismatch,
  input logic [tucv_pkg::COUNTER_WIDTH-1:0] frames_seen
);

  `ASSERT_ALWAYS(a_reset_clears_result, clk, rst |=> !result_valid)

  `ASSERT_CLK(a_stalled_result_holds, clk, rst,
    (result_valid && result_stall) |=> (result_valid && $stable(frames_seen)))

  `ASSERT_CLK(a_unchecked_zero, clk, rst,
    (result_valid && transport_kind == tucv_pkg::KIND_NONE) |->
      (computed_checksum == 16'd0 && received_checksum == 16'd0 && !checksum_mismatch))

  `ASSERT_CLK(a_mismatch_flag, clk, rst,
    (result_valid && transport_kind != tucv_pkg::KIND_NONE) |->
      (checksum_mismatch == (computed_checksum != received_checksum)))

  `ASSERT_CLK(a_frame_count_steps, clk, rst,
    ((result_valid && !result_stall) ##1 result_valid) |->
      (frames_seen == $past(frames_seen) + tucv_pkg::COUNTER_WIDTH'(1)))

endmodule

bind tcp_udp_checksum_verifier tucv_checker u_tucv_checker (.*);
